### sv/muart_pkg.sv
`default_nettype none

package muart_pkg;

  // Receive ring geometry
  localparam int RX_DEPTH = 8;
  localparam int PTR_W    = (RX_DEPTH > 1) ? $clog2(RX_DEPTH) : 1;
  localparam int FILL_W   = $clog2(RX_DEPTH + 1);
  localparam int SUM_W    = FILL_W + 1;

  // Field widths
  localparam int KIND_W  = 2;
  localparam int OFS_W   = 6;
  localparam int BYTE_W  = 8;
  localparam int RDATA_W = 24;
  localparam int LVL_W   = 8;

  // Item kinds
  typedef enum logic [KIND_W-1:0] {
    KIND_READ  = 2'd0,
    KIND_WRITE = 2'd1,
    KIND_RX    = 2'd2
  } kind_e;

  // Register offsets
  localparam logic [OFS_W-1:0] OFS_IO   = 6'h00;
  localparam logic [OFS_W-1:0] OFS_IER  = 6'h04;
  localparam logic [OFS_W-1:0] OFS_IIR  = 6'h08;
  localparam logic [OFS_W-1:0] OFS_LSR  = 6'h14;
  localparam logic [OFS_W-1:0] OFS_CNTL = 6'h20;
  localparam logic [OFS_W-1:0] OFS_STAT = 6'h24;

  // Fixed read words
  localparam logic [RDATA_W-1:0] IER_BASE     = 24'h0000c0;
  localparam logic [RDATA_W-1:0] IIR_BASE     = 24'h0000c0;
  localparam logic [RDATA_W-1:0] IIR_RX_AVAIL = 24'h000004;
  localparam logic [RDATA_W-1:0] IIR_TX_EMPTY = 24'h000002;
  localparam logic [RDATA_W-1:0] IIR_NO_INT   = 24'h000001;
  localparam logic [RDATA_W-1:0] LSR_BASE     = 24'h000060;
  localparam logic [RDATA_W-1:0] LSR_RX_READY = 24'h000001;
  localparam logic [RDATA_W-1:0] CNTL_VAL     = 24'h000003;
  localparam logic [RDATA_W-1:0] STAT_BASE    = 24'h00030e;
  localparam logic [RDATA_W-1:0] STAT_RX_AVAIL = 24'h000001;

  // Interrupt bits
  localparam int INT_RX  = 0;
  localparam int INT_TX  = 1;
  localparam int INT_W   = 2;
  localparam int FLUSH_BIT = 1;

  // Controller to datapath commands
  typedef struct packed {
    logic load;
    logic exec;
  } cmd_t;

endpackage

`default_nettype wire

### sv/muart_ifs.sv
`default_nettype none

// Request channel: bus access or received byte
interface muart_in_if;
  logic                           valid;
  logic                           ready;
  logic [muart_pkg::KIND_W-1:0]   kind;
  logic [muart_pkg::OFS_W-1:0]    reg_offset;
  logic [muart_pkg::BYTE_W-1:0]   write_data;
  logic [muart_pkg::BYTE_W-1:0]   rx_byte;

  modport source (output valid, kind, reg_offset, write_data, rx_byte, input ready);
  modport sink   (input valid, kind, reg_offset, write_data, rx_byte, output ready);
endinterface

// Result channel
interface muart_out_if;
  logic                           valid;
  logic                           ready;
  logic [muart_pkg::RDATA_W-1:0]  read_data;
  logic                           tx_valid;
  logic [muart_pkg::BYTE_W-1:0]   tx_byte;
  logic                           irq;
  logic                           rx_space;
  logic                           rx_dropped;

  modport source (output valid, read_data, tx_valid, tx_byte, irq, rx_space, rx_dropped,
                  input ready);
  modport sink   (input valid, read_data, tx_valid, tx_byte, irq, rx_space, rx_dropped,
                  output ready);
endinterface

`default_nettype wire

### sv/muart_ram.sv
`default_nettype none

module muart_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8
) (
  input  wire logic                                        clk_i,
  input  wire logic                                        we_i,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]                            wdata_i,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output      logic [WIDTH-1:0]                            rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

`default_nettype wire

### sv/muart_ctrl.sv
`default_nettype none

module muart_ctrl (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            in_valid_i,
  output      logic            in_ready_o,
  output      logic            out_valid_o,
  input  wire logic            out_ready_i,
  output      muart_pkg::cmd_t cmd_o
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_OUT
  } state_e;

  state_e state_q;
  logic   in_ready_q;
  logic   out_valid_q;

  // Commands to the datapath
  always_comb begin
    cmd_o.load = in_valid_i && in_ready_q;
    cmd_o.exec = (state_q == S_EXEC);
  end

  // State and registered handshake outputs
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      in_ready_q  <= 1'b1;
      out_valid_q <= 1'b0;
    end else begin
      unique case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            state_q    <= S_EXEC;
            in_ready_q <= 1'b0;
          end
        end
        S_EXEC: begin
          state_q     <= S_OUT;
          out_valid_q <= 1'b1;
        end
        S_OUT: begin
          if (out_ready_i) begin
            state_q     <= S_IDLE;
            out_valid_q <= 1'b0;
            in_ready_q  <= 1'b1;
          end
        end
        default: begin
          state_q     <= S_IDLE;
          in_ready_q  <= 1'b1;
          out_valid_q <= 1'b0;
        end
      endcase
    end
  end

  assign in_ready_o  = in_ready_q;
  assign out_valid_o = out_valid_q;

endmodule

`default_nettype wire

### sv/muart_dp.sv
`default_nettype none

module muart_dp (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire muart_pkg::cmd_t                   cmd_i,
  input  wire logic [muart_pkg::KIND_W-1:0]      kind_i,
  input  wire logic [muart_pkg::OFS_W-1:0]       reg_offset_i,
  input  wire logic [muart_pkg::BYTE_W-1:0]      write_data_i,
  input  wire logic [muart_pkg::BYTE_W-1:0]      rx_byte_i,
  output      logic [muart_pkg::RDATA_W-1:0]     read_data_o,
  output      logic                              tx_valid_o,
  output      logic [muart_pkg::BYTE_W-1:0]      tx_byte_o,
  output      logic                              irq_o,
  output      logic                              rx_space_o,
  output      logic                              rx_dropped_o
);

  // Latched item
  logic [muart_pkg::KIND_W-1:0]  kind_q;
  logic [muart_pkg::OFS_W-1:0]   ofs_q;
  logic [muart_pkg::BYTE_W-1:0]  wdata_q;
  logic [muart_pkg::BYTE_W-1:0]  rbyte_q;

  // Block state
  logic [muart_pkg::PTR_W-1:0]   head_q, head_d;
  logic [muart_pkg::FILL_W-1:0]  fill_q, fill_d;
  logic [muart_pkg::INT_W-1:0]   ien_q, ien_d;
  logic [muart_pkg::INT_W-1:0]   pend_q, pend_d;
  logic [muart_pkg::RX_DEPTH-1:0] valid_q, valid_d;

  // Ring port
  logic                          ram_we;
  logic [muart_pkg::PTR_W-1:0]   slot;
  logic [muart_pkg::SUM_W-1:0]   slot_sum;
  logic [muart_pkg::BYTE_W-1:0]  ram_rdata;
  logic                          rd_valid_q;
  logic [muart_pkg::BYTE_W-1:0]  ring_word;
  logic                          fill_nz;

  // Result
  logic [muart_pkg::RDATA_W-1:0] rdata_q, rdata_d;
  logic                          txv_q, txv_d;
  logic [muart_pkg::BYTE_W-1:0]  txb_q, txb_d;
  logic                          drop_q, drop_d;
  logic                          irq_q;
  logic                          space_q;

  muart_ram #(
    .WIDTH (muart_pkg::BYTE_W),
    .DEPTH (muart_pkg::RX_DEPTH)
  ) u_ring (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (slot),
    .wdata_i (rbyte_q),
    .raddr_i (head_q),
    .rdata_o (ram_rdata)
  );

  // Valid flag of the entry under the read pointer, aligned with the RAM read
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_valid_q <= 1'b0;
    end else begin
      rd_valid_q <= valid_q[head_q];
    end
  end

  // Capture the accepted item
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      kind_q  <= kind_i;
      ofs_q   <= reg_offset_i;
      wdata_q <= write_data_i;
      rbyte_q <= rx_byte_i;
    end
  end

  // Item execution
  always_comb begin
    head_d  = head_q;
    fill_d  = fill_q;
    ien_d   = ien_q;
    valid_d = valid_q;
    ram_we  = 1'b0;
    rdata_d = '0;
    txv_d   = 1'b0;
    txb_d   = '0;
    drop_d  = 1'b0;
    fill_nz = (fill_q != '0);
    ring_word = rd_valid_q ? ram_rdata : '0;

    // Tail slot = head + fill, wrapped
    slot_sum = muart_pkg::SUM_W'(head_q) + muart_pkg::SUM_W'(fill_q);
    if (slot_sum >= muart_pkg::SUM_W'(muart_pkg::RX_DEPTH)) begin
      slot_sum = slot_sum - muart_pkg::SUM_W'(muart_pkg::RX_DEPTH);
    end
    slot = slot_sum[muart_pkg::PTR_W-1:0];

    unique case (kind_q)
      muart_pkg::KIND_READ: begin
        unique case (ofs_q)
          muart_pkg::OFS_IO: begin
            rdata_d = muart_pkg::RDATA_W'(ring_word);
            if (fill_nz) begin
              fill_d = fill_q - muart_pkg::FILL_W'(1);
              if (head_q == muart_pkg::PTR_W'(muart_pkg::RX_DEPTH - 1)) begin
                head_d = '0;
              end else begin
                head_d = head_q + muart_pkg::PTR_W'(1);
              end
            end
          end
          muart_pkg::OFS_IER: begin
            rdata_d = muart_pkg::IER_BASE | muart_pkg::RDATA_W'(ien_q);
          end
          muart_pkg::OFS_IIR: begin
            rdata_d = muart_pkg::IIR_BASE
                    | (fill_nz ? muart_pkg::IIR_RX_AVAIL : muart_pkg::IIR_TX_EMPTY)
                    | ((pend_q == '0) ? muart_pkg::IIR_NO_INT : '0);
          end
          muart_pkg::OFS_LSR: begin
            rdata_d = muart_pkg::LSR_BASE | (fill_nz ? muart_pkg::LSR_RX_READY : '0);
          end
          muart_pkg::OFS_CNTL: begin
            rdata_d = muart_pkg::CNTL_VAL;
          end
          muart_pkg::OFS_STAT: begin
            rdata_d = muart_pkg::STAT_BASE;
            if (fill_nz) begin
              rdata_d = rdata_d | muart_pkg::STAT_RX_AVAIL
                      | {muart_pkg::LVL_W'(fill_q), 16'h0000};
            end
          end
          default: rdata_d = '0;
        endcase
      end
      muart_pkg::KIND_WRITE: begin
        unique case (ofs_q)
          muart_pkg::OFS_IO: begin
            txv_d = 1'b1;
            txb_d = wdata_q;
          end
          muart_pkg::OFS_IER: begin
            ien_d = wdata_q[muart_pkg::INT_W-1:0];
          end
          muart_pkg::OFS_IIR: begin
            if (wdata_q[muart_pkg::FLUSH_BIT]) begin
              fill_d = '0;
            end
          end
          default: ;
        endcase
      end
      muart_pkg::KIND_RX: begin
        if (fill_q < muart_pkg::FILL_W'(muart_pkg::RX_DEPTH)) begin
          ram_we        = cmd_i.exec;
          valid_d[slot] = 1'b1;
          fill_d        = fill_q + muart_pkg::FILL_W'(1);
        end else begin
          drop_d = 1'b1;
        end
      end
      default: ;
    endcase

    // Interrupt recompute from the updated state
    pend_d[muart_pkg::INT_RX] = ien_d[muart_pkg::INT_RX] && (fill_d != '0);
    pend_d[muart_pkg::INT_TX] = ien_d[muart_pkg::INT_TX];
  end

  // State update
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q  <= '0;
      fill_q  <= '0;
      ien_q   <= '0;
      pend_q  <= '0;
      valid_q <= '0;
    end else if (cmd_i.exec) begin
      head_q  <= head_d;
      fill_q  <= fill_d;
      ien_q   <= ien_d;
      pend_q  <= pend_d;
      valid_q <= valid_d;
    end
  end

  // Result register
  always_ff @(posedge clk_i) begin
    if (cmd_i.exec) begin
      rdata_q <= rdata_d;
      txv_q   <= txv_d;
      txb_q   <= txb_d;
      drop_q  <= drop_d;
      irq_q   <= (pend_d != '0);
      space_q <= (fill_d < muart_pkg::FILL_W'(muart_pkg::RX_DEPTH));
    end
  end

  assign read_data_o  = rdata_q;
  assign tx_valid_o   = txv_q;
  assign tx_byte_o    = txb_q;
  assign irq_o        = irq_q;
  assign rx_space_o   = space_q;
  assign rx_dropped_o = drop_q;

endmodule

`default_nettype wire

### sv/mini_uart_register_block_core.sv
// Mini UART register block with a receive ring.
// in_i carries one item per transfer: a bus read, a bus write, or a byte
// arriving from the serial line (kind 0, 1, 2). out_o returns exactly one
// result per item: read data, the transmit byte for data register writes,
// the interrupt level, ring space and a drop flag.
// An accepted item is latched, executed in the controller's EXEC state
// and its result registered; out_o.valid rises on entry to S_OUT.
// The controller holds one item at a time (accept, execute, deliver)
// and takes a new item only once the last result is delivered; the ring
// RAM has a registered read port that is addressed by the head pointer.
// While out_o is stalled the result holds and in_i.ready stays low, so
// no new item is taken until the result transfer completes.
// Reset clears head, fill, interrupt enables and pending bits and marks
// every ring entry as unwritten (reads as zero); the block is ready at
// once, no clearing pass is needed.
`default_nettype none

module mini_uart_register_block_core (
  input wire logic  clk_i,
  input wire logic  rst_ni,
  muart_in_if.sink  in_i,
  muart_out_if.source out_o
);

  muart_pkg::cmd_t cmd;

  muart_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .cmd_o       (cmd)
  );

  muart_dp u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .kind_i       (in_i.kind),
    .reg_offset_i (in_i.reg_offset),
    .write_data_i (in_i.write_data),
    .rx_byte_i    (in_i.rx_byte),
    .read_data_o  (out_o.read_data),
    .tx_valid_o   (out_o.tx_valid),
    .tx_byte_o    (out_o.tx_byte),
    .irq_o        (out_o.irq),
    .rx_space_o   (out_o.rx_space),
    .rx_dropped_o (out_o.rx_dropped)
  );

endmodule

`default_nettype wire

### sv/muart_chk.sv
`default_nettype none

module muart_chk (
  input wire logic                             clk_i,
  input wire logic                             rst_ni,
  input wire logic                             in_valid_i,
  input wire logic                             in_ready_i,
  input wire logic                             out_valid_i,
  input wire logic                             out_ready_i,
  input wire logic [muart_pkg::RDATA_W-1:0]    read_data_i,
  input wire logic                             tx_valid_i,
  input wire logic [muart_pkg::BYTE_W-1:0]     tx_byte_i,
  input wire logic                             rx_space_i,
  input wire logic                             rx_dropped_i
);

  // After a request transfer the result is valid once the execute state has passed
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_i) |=> !out_valid_i ##1 out_valid_i)
    else $error("result not delivered two cycles after request");

  // One item in flight: never ready for input while a result is pending
  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_ready_i && out_valid_i))
    else $error("input ready while result pending");

  // Stalled result holds
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && !out_ready_i) |=>
      (out_valid_i && $stable(read_data_i) && $stable(tx_byte_i)))
    else $error("stalled result changed");

  // Transmit byte is zero unless a byte is sent
  a_tx_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && !tx_valid_i) |-> (tx_byte_i == '0))
    else $error("tx byte nonzero without tx valid");

  // A dropped byte means the ring stayed full
  a_drop_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && rx_dropped_i) |-> !rx_space_i)
    else $error("byte dropped while ring had space");

endmodule

bind mini_uart_register_block_core muart_chk u_muart_chk (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_i.valid),
  .in_ready_i   (in_i.ready),
  .out_valid_i  (out_o.valid),
  .out_ready_i  (out_o.ready),
  .read_data_i  (out_o.read_data),
  .tx_valid_i   (out_o.tx_valid),
  .tx_byte_i    (out_o.tx_byte),
  .rx_space_i   (out_o.rx_space),
  .rx_dropped_i (out_o.rx_dropped)
);

`default_nettype wire

### tb/sv/mini_uart_register_block_core_tb.sv
`timescale 1ns / 1ps

module mini_uart_register_block_core_tb;
  import muart_pkg::*;

  // Registers with no storage in this block, and an unused item kind
  localparam logic [OFS_W-1:0]  OFS_LCR     = 6'h0c;
  localparam logic [OFS_W-1:0]  OFS_MCR     = 6'h10;
  localparam logic [OFS_W-1:0]  OFS_MSR     = 6'h18;
  localparam logic [OFS_W-1:0]  OFS_SCRATCH = 6'h1c;
  localparam logic [OFS_W-1:0]  OFS_BAUD    = 6'h28;
  localparam logic [OFS_W-1:0]  OFS_TOP     = 6'h3f;
  localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;

  localparam int CYCLE_LIMIT = 200000;
  localparam int MAX_GAP     = 18;
  localparam int LONG_HOLD   = 60;
  localparam int DRAIN_WAIT  = 8;

  typedef struct packed {
    logic [RDATA_W-1:0] read_data;
    logic               tx_valid;
    logic [BYTE_W-1:0]  tx_byte;
    logic               irq;
    logic               rx_space;
    logic               rx_dropped;
  } uart_resp_t;

  logic clk_i;
  logic rst_ni;

  muart_in_if  in_if ();
  muart_out_if out_if ();

  mini_uart_register_block_core u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  // Shadow copy of the register block state
  logic [BYTE_W-1:0] ring_mem [RX_DEPTH];
  int unsigned       ring_head;
  int unsigned       ring_fill;
  logic [INT_W-1:0]  irq_enable;
  logic [INT_W-1:0]  irq_pending;

  uart_resp_t awaited_responses [$];
  int         error_count;
  int         cycle_count;
  bit         src_gaps_on;
  bit         sink_gaps_on;
  int         sink_hold_cycles;

  logic [OFS_W-1:0] known_offsets [11] = '{OFS_IO, OFS_IER, OFS_IIR, OFS_LCR, OFS_MCR,
                                          OFS_LSR, OFS_MSR, OFS_SCRATCH, OFS_CNTL,
                                          OFS_STAT, OFS_BAUD};

  // Clock
  initial clk_i = 1'b0;
  always #2 clk_i = ~clk_i;

  // Next state and response of the block for one item
  function automatic uart_resp_t compute_uart_response(input logic [KIND_W-1:0] kind,
                                                       input logic [OFS_W-1:0]  ofs,
                                                       input logic [BYTE_W-1:0] wdata,
                                                       input logic [BYTE_W-1:0] rbyte);
    uart_resp_t  resp;
    int unsigned slot;
    resp = '0;
    case (kind)
      KIND_READ: begin
        case (ofs)
          OFS_IO: begin
            resp.read_data = RDATA_W'(ring_mem[ring_head]);
            if (ring_fill > 0) begin
              ring_fill--;
              ring_head = (ring_head + 1 == RX_DEPTH) ? 0 : ring_head + 1;
            end
          end
          OFS_IER:  resp.read_data = IER_BASE | RDATA_W'(irq_enable);
          OFS_IIR: begin
            resp.read_data = IIR_BASE | ((ring_fill != 0) ? IIR_RX_AVAIL : IIR_TX_EMPTY);
            if (irq_pending == '0) resp.read_data |= IIR_NO_INT;
          end
          OFS_LSR:  resp.read_data = LSR_BASE | ((ring_fill != 0) ? LSR_RX_READY : '0);
          OFS_CNTL: resp.read_data = CNTL_VAL;
          OFS_STAT: begin
            resp.read_data = STAT_BASE;
            if (ring_fill != 0)
              resp.read_data |= STAT_RX_AVAIL | (RDATA_W'(ring_fill & 8'hff) << 16);
          end
          default: resp.read_data = '0;
        endcase
      end
      KIND_WRITE: begin
        if (ofs == OFS_IO) begin
          resp.tx_valid = 1'b1;
          resp.tx_byte  = wdata;
        end else if (ofs == OFS_IER) begin
          irq_enable = wdata[INT_W-1:0];
        end else if (ofs == OFS_IIR && wdata[FLUSH_BIT]) begin
          ring_fill = 0;
        end
      end
      KIND_RX: begin
        if (ring_fill < RX_DEPTH) begin
          slot = ring_head + ring_fill;
          if (slot >= RX_DEPTH) slot -= RX_DEPTH;
          ring_mem[slot] = rbyte;
          ring_fill++;
        end else begin
          resp.rx_dropped = 1'b1;
        end
      end
      default: ;
    endcase
    // interrupt state is refreshed after every item
    irq_pending[INT_RX] = irq_enable[INT_RX] && (ring_fill != 0);
    irq_pending[INT_TX] = irq_enable[INT_TX];
    resp.irq      = (irq_pending != '0);
    resp.rx_space = (ring_fill < RX_DEPTH);
    return resp;
  endfunction

  // Offer one item, wait for its transfer, then queue its expected response
  task automatic send_item(input logic [KIND_W-1:0] kind, input logic [OFS_W-1:0] ofs,
                           input logic [BYTE_W-1:0] wdata, input logic [BYTE_W-1:0] rbyte);
    int gap;
    gap = src_gaps_on ? $urandom_range(0, MAX_GAP) : 0;
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_if.valid      <= 1'b1;
    in_if.kind       <= kind;
    in_if.reg_offset <= ofs;
    in_if.write_data <= wdata;
    in_if.rx_byte    <= rbyte;
    do @(posedge clk_i); while (!(in_if.valid && in_if.ready));
    awaited_responses.push_back(compute_uart_response(kind, ofs, wdata, rbyte));
  endtask

  function automatic logic [OFS_W-1:0] pick_offset();
    if ($urandom_range(0, 99) < 80) return known_offsets[$urandom_range(0, 10)];
    return OFS_W'($urandom_range(0, 63));
  endfunction

  // Random item; arrive_pct and pop_pct steer the ring fill level
  task automatic send_random_item(input int arrive_pct, input int pop_pct);
    int               roll;
    logic [KIND_W-1:0] kind;
    logic [OFS_W-1:0]  ofs;
    roll = $urandom_range(0, 99);
    ofs  = pick_offset();
    if (roll < arrive_pct) begin
      kind = KIND_RX;
    end else if (roll < arrive_pct + pop_pct) begin
      kind = KIND_READ;
      ofs  = OFS_IO;
    end else if (roll < 96) begin
      kind = $urandom_range(0, 1) ? KIND_READ : KIND_WRITE;
    end else begin
      kind = KIND_UNUSED;
    end
    send_item(kind, ofs, BYTE_W'($urandom_range(0, 255)), BYTE_W'($urandom_range(0, 255)));
  endtask

  // Reset view of every register, unmapped and unaligned offsets, unused kind
  task automatic test_register_map();
    send_item(KIND_READ, OFS_IO, 8'h00, 8'h00);
    send_item(KIND_READ, OFS_IER, 8'h00, 8'h00);
    send_item(KIND_READ, OFS_IIR, 8'h00, 8'h00);
    send_item(KIND_READ, OFS_LSR, 8'h00, 8'h00);
    send_item(KIND_READ, OFS_CNTL, 8'h00, 8'h00);
    send_item(KIND_READ, OFS_STAT, 8'h00, 8'h00);
    send_item(KIND_READ, OFS_LCR, 8'h00, 8'h00);
    send_item(KIND_READ, OFS_TOP, 8'hff, 8'hff);
    send_item(KIND_UNUSED, OFS_TOP, 8'hff, 8'hff);
  endtask

  // Transmit path and interrupt enables
  task automatic test_tx_and_enables();
    send_item(KIND_WRITE, OFS_IO, 8'hff, 8'h00);
    send_item(KIND_WRITE, OFS_IO, 8'h00, 8'hff);
    send_item(KIND_WRITE, OFS_IER, 8'hff, 8'h00);
    send_item(KIND_READ, OFS_IER, 8'h00, 8'h00);
    send_item(KIND_WRITE, OFS_IER, 8'h01, 8'h00);
  endtask

  // Fill the ring, overflow it, read the full level, pop one byte, flush, then a stale read
  task automatic test_ring_overflow();
    for (int i = 0; i <= RX_DEPTH; i++)
      send_item(KIND_RX, OFS_IO, 8'h00, (i % 2) ? 8'hff : BYTE_W'(i * 8'h11));
    send_item(KIND_READ, OFS_STAT, 8'h00, 8'h00);
    send_item(KIND_READ, OFS_IO, 8'h00, 8'h00);
    send_item(KIND_WRITE, OFS_IIR, 8'h02, 8'h00);
    send_item(KIND_READ, OFS_IO, 8'h00, 8'h00);
  endtask

  // Random items in segments with shifting mixes and idling patterns
  task automatic test_random_traffic(input int segments, input int per_segment);
    int arrive_pct;
    int pop_pct;
    for (int s = 0; s < segments; s++) begin
      case (s % 3)
        0: begin arrive_pct = 30; pop_pct = 25; end
        1: begin arrive_pct = 55; pop_pct = 10; end
        default: begin arrive_pct = 15; pop_pct = 45; end
      endcase
      src_gaps_on  = (s % 3 != 2);
      sink_gaps_on = (s % 4 != 3);
      for (int i = 0; i < per_segment; i++) send_random_item(arrive_pct, pop_pct);
    end
  endtask

  // Receiver holds off for a long stretch while items keep coming
  task automatic test_output_backpressure();
    src_gaps_on      = 1'b0;
    sink_hold_cycles = LONG_HOLD;
    for (int i = 0; i < 12; i++) send_random_item(40, 30);
  endtask

  // Sender idles until every response is in, then resumes
  task automatic test_drain_and_resume();
    in_if.valid <= 1'b0;
    wait (awaited_responses.size() == 0);
    @(posedge clk_i);
    src_gaps_on = 1'b1;
    for (int i = 0; i < 10; i++) send_random_item(35, 30);
  endtask

  // Main sequence
  initial begin
    rst_ni           <= 1'b0;
    in_if.valid      <= 1'b0;
    in_if.kind       <= KIND_READ;
    in_if.reg_offset <= '0;
    in_if.write_data <= '0;
    in_if.rx_byte    <= '0;
    error_count      = 0;
    sink_hold_cycles = 0;
    src_gaps_on      = 1'b1;
    sink_gaps_on     = 1'b1;
    ring_head        = 0;
    ring_fill        = 0;
    irq_enable       = '0;
    irq_pending      = '0;
    foreach (ring_mem[i]) ring_mem[i] = '0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_register_map();
    test_tx_and_enables();
    test_ring_overflow();
    test_random_traffic(4, 50);
    test_output_backpressure();
    test_drain_and_resume();
    test_random_traffic(4, 50);

    in_if.valid <= 1'b0;
    wait (awaited_responses.size() == 0);
    repeat (DRAIN_WAIT) @(posedge clk_i);
    if (error_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  // Result receiver: random stalls plus an optional long hold-off
  initial begin
    int stall;
    out_if.ready <= 1'b0;
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      stall = (sink_gaps_on ? $urandom_range(0, MAX_GAP) : 0) + sink_hold_cycles;
      sink_hold_cycles = 0;
      if (stall > 0) begin
        out_if.ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_if.ready <= 1'b1;
      do @(posedge clk_i); while (!(out_if.valid && out_if.ready));
    end
  end

  // Compare each result transfer with the oldest expectation
  always @(posedge clk_i) begin
    uart_resp_t want;
    if (rst_ni && out_if.valid && out_if.ready) begin
      if (awaited_responses.size() == 0) begin
        $error("unexpected response: read_data %0h tx_valid %0b", out_if.read_data,
               out_if.tx_valid);
        error_count++;
      end else begin
        want = awaited_responses.pop_front();
        if (out_if.read_data !== want.read_data) begin
          $error("read_data mismatch: expected %0h, got %0h", want.read_data,
                 out_if.read_data);
          error_count++;
        end
        if (out_if.tx_valid !== want.tx_valid) begin
          $error("tx_valid mismatch: expected %0b, got %0b", want.tx_valid, out_if.tx_valid);
          error_count++;
        end
        if (out_if.tx_byte !== want.tx_byte) begin
          $error("tx_byte mismatch: expected %0h, got %0h", want.tx_byte, out_if.tx_byte);
          error_count++;
        end
        if (out_if.irq !== want.irq) begin
          $error("irq mismatch: expected %0b, got %0b", want.irq, out_if.irq);
          error_count++;
        end
        if (out_if.rx_space !== want.rx_space) begin
          $error("rx_space mismatch: expected %0b, got %0b", want.rx_space, out_if.rx_space);
          error_count++;
        end
        if (out_if.rx_dropped !== want.rx_dropped) begin
          $error("rx_dropped mismatch: expected %0b, got %0b", want.rx_dropped,
                 out_if.rx_dropped);
          error_count++;
        end
      end
    end
  end

  // Watchdog
  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
